[design/sorted_insert_table_top_assert.svh]
// ----------------------------------------------------------------------------
// sorted_insert_table_top_assert.svh
// Assertion macros used by the sorted insert table top.
// ----------------------------------------------------------------------------
`ifndef SORTED_INSERT_TABLE_TOP_ASSERT_SVH
`define SORTED_INSERT_TABLE_TOP_ASSERT_SVH

// Condition holds at every clock edge outside reset.
`define SIT_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

// Consequent holds in the same cycle as the antecedent.
`define SIT_ASSERT_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define SIT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[design/sit_pkg.sv]
// ----------------------------------------------------------------------------
// sit_pkg
// Types, widths and codes shared by the sorted insert table modules.
// ----------------------------------------------------------------------------
package sit_pkg;

    localparam int CAPACITY = 64;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    localparam int HANDLE_W = 8;
    localparam int DEPTH_W  = 16;
    localparam int POS_W    = 6;
    localparam int ECNT_W   = 7;
    localparam int STATUS_W = 2;

    // wide enough to compare position, count and capacity without loss
    localparam int CMP_A    = (CNT_W > POS_W) ? CNT_W : POS_W;
    localparam int CMP_W    = (CMP_A > ECNT_W) ? CMP_A : ECNT_W;

    localparam int IN_BITS    = HANDLE_W + DEPTH_W + POS_W;
    localparam int IN_DATA_W  = ((IN_BITS + 7) / 8) * 8;
    localparam int OUT_BITS   = HANDLE_W + DEPTH_W + ECNT_W;
    localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;

    typedef enum logic [0:0] {
        ACT_INSERT = 1'b0,
        ACT_READ   = 1'b1
    } action_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_RANGE = 2'd2
    } status_t;

    // read address source
    typedef enum logic [1:0] {
        RA_TOP   = 2'd0,  // last stored entry
        RA_POS   = 2'd1,  // requested position
        RA_BELOW = 2'd2   // entry below the one just shifted
    } rd_sel_t;

    typedef struct packed {
        logic [HANDLE_W-1:0]       handle;
        logic signed [DEPTH_W-1:0] depth;
    } entry_t;

    typedef struct packed {
        logic    latch_in;
        logic    rd_en;
        rd_sel_t rd_sel;
        logic    slot_load;
        logic    slot_dec;
        logic    wr_shift;
        logic    wr_place;
        logic    cnt_inc;
        logic    res_load;
        status_t res_status;
        logic    res_use_rd;
        logic    out_load;
    } sit_cmd_t;

    typedef struct packed {
        action_t action;
        logic    full;
        logic    empty;
        logic    range_err;
        logic    greater;
        logic    slot_one;
        logic    out_free;
    } sit_stat_t;

endpackage

[design/sit_ctrl.sv]
// ----------------------------------------------------------------------------
// sit_ctrl
// Sequencer for insert and read words of the sorted insert table.
// ----------------------------------------------------------------------------
module sit_ctrl
    import sit_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      s_tvalid,
    output logic      s_tready,
    input  sit_stat_t stat,
    output sit_cmd_t  cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_START,
        S_SHIFT,
        S_RDWAIT,
        S_PLACE,
        S_RESP
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign s_tready = (state_reg == S_IDLE);

    always_comb
    begin
        cmd        = '0;
        cmd.rd_sel = RA_TOP;
        cmd.res_status = ST_OK;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.latch_in = 1'b1;
                    state_next   = S_START;
                end
            end
            S_START:
            begin
                if (stat.action == ACT_INSERT)
                begin
                    if (stat.full)
                    begin
                        cmd.res_load   = 1'b1;
                        cmd.res_status = ST_FULL;
                        state_next     = S_RESP;
                    end
                    else if (stat.empty)
                    begin
                        cmd.slot_load = 1'b1;
                        state_next    = S_PLACE;
                    end
                    else
                    begin
                        cmd.rd_en     = 1'b1;
                        cmd.rd_sel    = RA_TOP;
                        cmd.slot_load = 1'b1;
                        state_next    = S_SHIFT;
                    end
                end
                else
                begin
                    if (stat.range_err)
                    begin
                        cmd.res_load   = 1'b1;
                        cmd.res_status = ST_RANGE;
                        state_next     = S_RESP;
                    end
                    else
                    begin
                        cmd.rd_en  = 1'b1;
                        cmd.rd_sel = RA_POS;
                        state_next = S_RDWAIT;
                    end
                end
            end
            S_SHIFT:
            begin
                if (stat.greater)
                begin
                    // move the larger entry up one slot, then look below
                    cmd.wr_shift = 1'b1;
                    cmd.slot_dec = 1'b1;
                    if (stat.slot_one)
                    begin
                        state_next = S_PLACE;
                    end
                    else
                    begin
                        cmd.rd_en  = 1'b1;
                        cmd.rd_sel = RA_BELOW;
                    end
                end
                else
                begin
                    cmd.wr_place = 1'b1;
                    cmd.cnt_inc  = 1'b1;
                    cmd.res_load = 1'b1;
                    state_next   = S_RESP;
                end
            end
            S_RDWAIT:
            begin
                cmd.res_load   = 1'b1;
                cmd.res_use_rd = 1'b1;
                state_next     = S_RESP;
            end
            S_PLACE:
            begin
                cmd.wr_place = 1'b1;
                cmd.cnt_inc  = 1'b1;
                cmd.res_load = 1'b1;
                state_next   = S_RESP;
            end
            S_RESP:
            begin
                if (stat.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

[design/sit_dp.sv]
// ----------------------------------------------------------------------------
// sit_dp
// Entry memory, count, insert slot and output register of the sorted table.
// ----------------------------------------------------------------------------
module sit_dp
    import sit_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic [IN_DATA_W-1:0]  s_tdata,
    input  logic                  s_tuser,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,
    output logic [STATUS_W-1:0]   m_tuser,
    input  sit_cmd_t              cmd,
    output sit_stat_t             stat
);

    entry_t mem [CAPACITY];
    entry_t rd_q_reg;

    action_t                   act_reg;
    logic [HANDLE_W-1:0]       handle_reg;
    logic signed [DEPTH_W-1:0] depth_reg;
    logic [POS_W-1:0]          pos_reg;
    logic [CNT_W-1:0]          count_reg;
    logic [IDX_W-1:0]          slot_reg;

    status_t                   res_status_reg;
    entry_t                    res_entry_reg;

    logic                      m_valid_reg;
    entry_t                    out_entry_reg;
    logic [ECNT_W-1:0]         out_cnt_reg;
    status_t                   out_status_reg;

    logic [CMP_W-1:0]          pos_ext;
    logic [CMP_W-1:0]          count_ext;
    logic [IDX_W-1:0]          rd_addr;
    entry_t                    wr_data;
    entry_t                    new_entry;

    assign pos_ext   = CMP_W'(pos_reg);
    assign count_ext = CMP_W'(count_reg);
    assign new_entry = '{handle: handle_reg, depth: depth_reg};

    always_comb
    begin
        unique case (cmd.rd_sel)
            RA_TOP:   rd_addr = count_reg[IDX_W-1:0] - IDX_W'(1);
            RA_POS:   rd_addr = pos_ext[IDX_W-1:0];
            RA_BELOW: rd_addr = slot_reg - IDX_W'(2);
            default:  rd_addr = '0;
        endcase
    end

    assign wr_data = cmd.wr_shift ? rd_q_reg : new_entry;

    // entry memory: one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (cmd.wr_shift || cmd.wr_place)
        begin
            mem[slot_reg] <= wr_data;
        end
        if (cmd.rd_en)
        begin
            rd_q_reg <= mem[rd_addr];
        end
    end

    // input item, insert slot, result and output payload
    always_ff @(posedge clk)
    begin
        if (cmd.latch_in)
        begin
            act_reg    <= action_t'(s_tuser);
            handle_reg <= s_tdata[HANDLE_W-1:0];
            depth_reg  <= s_tdata[HANDLE_W +: DEPTH_W];
            pos_reg    <= s_tdata[HANDLE_W + DEPTH_W +: POS_W];
        end
        if (cmd.slot_load)
        begin
            slot_reg <= count_reg[IDX_W-1:0];
        end
        else if (cmd.slot_dec)
        begin
            slot_reg <= slot_reg - IDX_W'(1);
        end
        if (cmd.res_load)
        begin
            res_status_reg <= cmd.res_status;
            res_entry_reg  <= cmd.res_use_rd ? rd_q_reg : '0;
        end
        if (cmd.out_load)
        begin
            out_entry_reg  <= res_entry_reg;
            out_cnt_reg    <= count_ext[ECNT_W-1:0];
            out_status_reg <= res_status_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.cnt_inc)
            begin
                count_reg <= count_reg + CNT_W'(1);
            end
            if (cmd.out_load)
            begin
                m_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign stat.action    = act_reg;
    assign stat.full      = (count_reg == CNT_W'(CAPACITY));
    assign stat.empty     = (count_reg == '0);
    assign stat.range_err = (pos_ext >= count_ext) || (pos_ext >= CMP_W'(CAPACITY));
    assign stat.greater   = ($signed(rd_q_reg.depth) > $signed(depth_reg));
    assign stat.slot_one  = (slot_reg == IDX_W'(1));
    assign stat.out_free  = !m_valid_reg || m_tready;

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = OUT_DATA_W'({out_cnt_reg, out_entry_reg.depth, out_entry_reg.handle});
    assign m_tuser  = out_status_reg;

endmodule

[design/sorted_insert_table_top.sv]
// ----------------------------------------------------------------------------
// sorted_insert_table_top
// Table of handle/depth entries kept in stable ascending depth order.
// ----------------------------------------------------------------------------
// Each input word either inserts an entry (s_tuser = 0) or reads the entry at
// a sorted position (s_tuser = 1), and each gives exactly one output word with
// a status in m_tuser: ok, full (insert dropped) or position out of range.
// A new entry goes after every stored entry of lower or equal depth, so equal
// depths keep arrival order. Words are handled one at a time. An insert walks
// down from the top of the table through an entry memory with one write port
// and one read port, moving one larger entry up per cycle past at most
// CAPACITY - 1 entries before it reaches the output register. One more word
// is accepted as soon as its predecessor has reached the output register,
// even while that result still waits for m_tready. The memory needs no
// clearing after reset: only positions below the entry count are ever read.
// ----------------------------------------------------------------------------
module sorted_insert_table_top
    import sit_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // item_handle[7:0], item_depth[23:8], read_position[29:24], zero pad
    input  logic [IN_DATA_W-1:0]  s_tdata,
    // action[0]: 0 insert, 1 read
    input  logic                  s_tuser,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // out_handle[7:0], out_depth[23:8], entry_count[30:24], zero pad
    output logic [OUT_DATA_W-1:0] m_tdata,
    // status[1:0]: 0 ok, 1 full, 2 out of range
    output logic [STATUS_W-1:0]   m_tuser
);

`include "sorted_insert_table_top_assert.svh"

    localparam int OUT_DEPTH_LO = HANDLE_W;
    localparam int OUT_CNT_LO   = HANDLE_W + DEPTH_W;

    sit_cmd_t  ctrl_cmd;
    sit_stat_t dp_stat;

    // sequencer: decides each step of an insert or read
    sit_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (dp_stat),
        .cmd      (ctrl_cmd)
    );

    // datapath: entry memory, count, slot pointer and output register
    sit_dp u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .cmd      (ctrl_cmd),
        .stat     (dp_stat)
    );

    // a shift and a placement never share the single write port
    `SIT_ASSERT_ALWAYS(a_one_write, !(ctrl_cmd.wr_shift && ctrl_cmd.wr_place), "two memory writes in one cycle")

    // a dropped insert is only reported with the table at capacity
    `SIT_ASSERT_IMPLIES(a_full_count, m_tvalid && (m_tuser == ST_FULL), m_tdata[OUT_CNT_LO +: ECNT_W] == ECNT_W'(CAPACITY), "full status below capacity")

    // an out-of-range read returns zero handle and depth
    `SIT_ASSERT_IMPLIES(a_range_zero, m_tvalid && (m_tuser == ST_RANGE), m_tdata[OUT_CNT_LO-1:0] == '0, "out-of-range read with nonzero entry")

    // one word in flight: no acceptance right after an acceptance
    `SIT_ASSERT_NEXT(a_one_item, s_tvalid && s_tready, !s_tready, "second word accepted while busy")

endmodule

[tb/sv/tb_sorted_insert_table_top.sv]
// ----------------------------------------------------------------------------
// tb_sorted_insert_table_top
// Self-checking bench for the stable sorted insert table.
// ----------------------------------------------------------------------------
// Drives insert and read words into the table and checks every output word
// against a software copy of the table that is kept in step with each
// accepted word. A short directed list covers the depth extremes, ties,
// reads on an empty table and reads past the entry count. A random part then
// fills the table to capacity and keeps inserting and reading once it is
// full. Both stream sides idle at random, with one long stretch at full rate.
// ----------------------------------------------------------------------------
module tb_sorted_insert_table_top;
    import sit_pkg::*;

    // expected contents of one output word
    typedef struct packed {
        logic [HANDLE_W-1:0]       handle;
        logic signed [DEPTH_W-1:0] depth;
        logic [ECNT_W-1:0]         count;
        status_t                   status;
    } table_result_t;

    // one row of the directed list; want is used only where typed is set
    typedef struct packed {
        action_t                   act;
        logic [HANDLE_W-1:0]       handle;
        logic signed [DEPTH_W-1:0] depth;
        logic [POS_W-1:0]          pos;
        logic                      typed;
        table_result_t             want;
    } stim_row_t;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 80;
    localparam int RANDOM_WORDS = 450;

    logic                  clk;
    logic                  rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata;
    logic                  s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic [STATUS_W-1:0]   m_tuser;

    // shadow copy of the table
    logic signed [DEPTH_W-1:0] tbl_depth  [CAPACITY];
    logic [HANDLE_W-1:0]       tbl_handle [CAPACITY];
    int                        tbl_count;

    table_result_t pending_results[$];
    stim_row_t     directed_rows[$];

    int mismatch_cnt;
    int word_cnt;
    int cycle_cnt;
    int tx_idle_pct;
    int rx_idle_pct;

    sorted_insert_table_top uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #5 clk = ~clk;
        end
    end

    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
    end

    // Hard stop if the table hangs or a result never shows up.
    initial
    begin
        wait (cycle_cnt >= CYCLE_LIMIT);
        $display("** sorted_insert_table_top: FAILED **");
        $finish;
    end

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch on word %0d: %s got %0d want %0d", word_cnt, what, got, want);
        mismatch_cnt++;
    endtask

    // Apply one word to the shadow table and return the word it should produce.
    // Insert: walk down from the top, move every strictly deeper entry up one
    // slot, drop the new entry in the gap (equal depths stay in arrival order).
    function automatic table_result_t table_apply(action_t act,
                                                  logic [HANDLE_W-1:0] h,
                                                  logic signed [DEPTH_W-1:0] d,
                                                  logic [POS_W-1:0] pos);
        table_result_t r;
        int            slot;
        r        = '0;
        r.status = ST_OK;
        if (act == ACT_INSERT)
        begin
            if (tbl_count >= CAPACITY)
            begin
                r.status = ST_FULL;
            end
            else
            begin
                slot = tbl_count;
                while (slot > 0 && tbl_depth[slot-1] > d)
                begin
                    tbl_depth[slot]  = tbl_depth[slot-1];
                    tbl_handle[slot] = tbl_handle[slot-1];
                    slot--;
                end
                tbl_depth[slot]  = d;
                tbl_handle[slot] = h;
                tbl_count++;
            end
        end
        else if (int'(pos) < tbl_count)
        begin
            r.handle = tbl_handle[pos];
            r.depth  = tbl_depth[pos];
        end
        else
        begin
            r.status = ST_RANGE;
        end
        r.count = ECNT_W'(tbl_count);
        return r;
    endfunction

    task automatic add_row(action_t act, int h, int d, int pos, bit typed,
                           int wh, int wd, int wc, status_t ws);
        stim_row_t row;
        row.act         = act;
        row.handle      = HANDLE_W'(h);
        row.depth       = DEPTH_W'(d);
        row.pos         = POS_W'(pos);
        row.typed       = typed;
        row.want.handle = HANDLE_W'(wh);
        row.want.depth  = DEPTH_W'(wd);
        row.want.count  = ECNT_W'(wc);
        row.want.status = ws;
        directed_rows.insert(directed_rows.size(), row);
    endtask

    // Present one word, hold it until accepted, then queue its expected result.
    // Entered and left at a falling edge; random idle cycles go in front.
    task automatic send_word(stim_row_t row);
        table_result_t predicted;
        while ($urandom_range(99) < tx_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= row.act;
        s_tdata  <= IN_DATA_W'({row.pos, row.depth, row.handle});
        @(posedge clk);
        while (!s_tready)
        begin
            @(posedge clk);
        end
        predicted = table_apply(row.act, row.handle, row.depth, row.pos);
        pending_results.insert(pending_results.size(), row.typed ? row.want : predicted);
        @(negedge clk);
    endtask

    // Drop valid and hold off until every queued result has come back.
    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
        begin
            @(negedge clk);
        end
    endtask

    // Result side: stall at random, one decision per cycle.
    always @(negedge clk)
    begin
        m_tready <= ($urandom_range(99) >= rx_idle_pct);
    end

    // Check every accepted output word against the oldest expectation.
    always @(posedge clk)
    begin : result_check
        table_result_t got;
        table_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.handle = m_tdata[HANDLE_W-1:0];
            got.depth  = m_tdata[HANDLE_W+DEPTH_W-1:HANDLE_W];
            got.count  = m_tdata[HANDLE_W+DEPTH_W+ECNT_W-1:HANDLE_W+DEPTH_W];
            got.status = status_t'(m_tuser);
            if (pending_results.size() == 0)
            begin
                report_mismatch("word with nothing pending, status", got.status, 0);
            end
            else
            begin
                want = pending_results.pop_front();
                if (got.status !== want.status)
                    report_mismatch("status", got.status, want.status);
                if (got.count !== want.count)
                    report_mismatch("entry_count", got.count, want.count);
                if (got.handle !== want.handle)
                    report_mismatch("out_handle", got.handle, want.handle);
                if (got.depth !== want.depth)
                    report_mismatch("out_depth", got.depth, want.depth);
            end
            word_cnt++;
        end
    end

    initial
    begin : stimulus
        stim_row_t row;
        int        i;
        int        sel;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        s_tuser      = ACT_INSERT;
        m_tready     = 1'b0;
        rst_n        = 1'b0;
        tbl_count    = 0;
        mismatch_cnt = 0;
        word_cnt     = 0;
        cycle_cnt    = 0;
        tx_idle_pct  = 7;
        rx_idle_pct  = 7;

        // reads on an empty table, both ends of the position range
        add_row(ACT_READ,   0,      0,  0, 1,    0,      0, 0, ST_RANGE);
        add_row(ACT_READ,   0,      0, 63, 1,    0,      0, 0, ST_RANGE);
        // depth extremes, the larger one first so the smaller moves it up
        add_row(ACT_INSERT, 'hFF,  32767, 0, 1, 0,      0, 1, ST_OK);
        add_row(ACT_INSERT, 'h00, -32768, 0, 1, 0,      0, 2, ST_OK);
        add_row(ACT_READ,   0,      0,  0, 1, 'h00, -32768, 2, ST_OK);
        add_row(ACT_READ,   0,      0,  1, 1, 'hFF,  32767, 2, ST_OK);
        add_row(ACT_READ,   0,      0,  2, 1,    0,      0, 2, ST_RANGE);
        // ties in the middle and at both extremes keep arrival order
        add_row(ACT_INSERT, 'h11,      0, 0, 0, 0, 0, 0, ST_OK);
        add_row(ACT_INSERT, 'h22,      0, 0, 0, 0, 0, 0, ST_OK);
        add_row(ACT_INSERT, 'h33,      0, 0, 0, 0, 0, 0, ST_OK);
        add_row(ACT_INSERT, 'h44,     -1, 0, 0, 0, 0, 0, ST_OK);
        add_row(ACT_INSERT, 'h55,      1, 0, 0, 0, 0, 0, ST_OK);
        add_row(ACT_INSERT, 'h66,  32767, 0, 0, 0, 0, 0, ST_OK);
        add_row(ACT_INSERT, 'h77, -32768, 0, 0, 0, 0, 0, ST_OK);
        for (i = 0; i < 9; i++)
            add_row(ACT_READ, 0, 0, i, 0, 0, 0, 0, ST_OK);
        // first position past the count, and the top position
        add_row(ACT_READ,   0,      0,  9, 1,    0,      0, 9, ST_RANGE);
        add_row(ACT_READ,   0,      0, 63, 1,    0,      0, 9, ST_RANGE);

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (directed_rows[k])
            send_word(directed_rows[k]);
        drain_results();

        // Random part: fill the table, then keep hammering it once full.
        // Depths lean toward a few small values and the extremes for ties.
        for (i = 0; i < RANDOM_WORDS; i++)
        begin
            tx_idle_pct = (i >= 100 && i < 200) ? 0 : 7;
            rx_idle_pct = tx_idle_pct;
            if (i == 300)
                drain_results();
            row = '0;
            if (tbl_count < CAPACITY)
                row.act = ($urandom_range(99) < 35) ? ACT_INSERT : ACT_READ;
            else
                row.act = ($urandom_range(99) < 15) ? ACT_INSERT : ACT_READ;
            row.handle = HANDLE_W'($urandom);
            sel = $urandom_range(7);
            case (sel)
                0, 1:    row.depth = DEPTH_W'(int'($urandom_range(4)) - 2);
                2:       row.depth = 16'sh7FFF;
                3:       row.depth = 16'sh8000;
                default: row.depth = DEPTH_W'($urandom);
            endcase
            if (tbl_count < CAPACITY && $urandom_range(3) == 0)
                row.pos = POS_W'(tbl_count);
            else
                row.pos = POS_W'($urandom);
            send_word(row);
        end
        drain_results();
        repeat (DRAIN_CYCLES) @(negedge clk);

        if (mismatch_cnt == 0 && pending_results.size() == 0)
            $display("** sorted_insert_table_top: PASSED **");
        else
            $display("** sorted_insert_table_top: FAILED **");
        $finish;
    end

endmodule

[sim.f]
+incdir+design
design/sit_pkg.sv
design/sit_ctrl.sv
design/sit_dp.sv
design/sorted_insert_table_top.sv
tb/sv/tb_sorted_insert_table_top.sv
